// ===== design/ephd_pkg.sv =====
// ----------------------------------------------------------------------------
// ephd_pkg
// Shared types, field widths and helpers of the peak hold event detector.
// ----------------------------------------------------------------------------
package ephd_pkg;

  // Fixed field widths
  localparam int OFF_W     = 11;  // window_offset input field
  localparam int CMD_OFF_W = 16;  // reduced offset, covers the largest ring
  localparam int PEAK_W    = 31;
  localparam int CNT_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int PROD_W    = 66;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SCALE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_RATE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT     = 2'd3;

  // Configuration reset values
  localparam logic [31:0]       SCALE_RESET     = 32'd97924;
  localparam logic [15:0]       RATE_RESET      = 16'd655;
  localparam logic [PEAK_W-1:0] THRESHOLD_RESET = 31'd1677722;
  localparam logic [15:0]       HOLD_RESET      = 16'd1000;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

  // Input action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // Command word handed from the front end to the back end
  typedef struct packed {
    logic                  is_read;
    logic signed [31:0]    sample;   // sign-extended converter sample
    logic [CMD_OFF_W-1:0]  offset;   // window offset, already below ring depth
  } cmd_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(64'sd2147483647);
    lo = PROD_W'(-64'sd2147483648);
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

endpackage

// ===== design/emg_peak_hold_detector_unit.sv =====
// ----------------------------------------------------------------------------
// emg_peak_hold_detector_unit
// DC-removal peak hold event detector with a captured sample window.
// ----------------------------------------------------------------------------
// Each input word either processes one converter sample (tuser low) or reads
// one entry of the captured window (tuser high); every word yields exactly one
// result word. For a sample the back end uses one shared 33x33 multiplier
// twice in series (gain, then mean weight), each product followed by a
// saturation step, then forms the centered value, and does peak hold,
// detection and the ring write as the result word is loaded. A window read
// passes the back end steps index, registered ring read and output; the front
// end holds each word and steps its offset down by RING_DEPTH until it lies
// below the ring depth. A two-entry queue lets the front end keep taking words
// while the back end works or waits on the output. Ring entries never written
// since reset read as zero through a fill mark, so no clearing pass follows
// reset.
module emg_peak_hold_detector_unit #(
  parameter int RING_DEPTH  = 2048,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                          clk,
  input  logic                                          rst,
  // Configuration write port
  input  logic                                          cfg_we,
  input  logic [ephd_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [ephd_pkg::CFG_W-1:0]                    cfg_data,
  // Input stream
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // s_tdata: raw_sample [SAMPLE_BITS], window_offset [11], zero pad
  input  logic [((SAMPLE_BITS+ephd_pkg::OFF_W+7)/8)*8-1:0] s_tdata,
  // s_tuser: action
  input  logic                                          s_tuser,
  // Output stream
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // m_tdata: centered_value [32], mean_value [32], peak_value [31],
  //          detected [1], window_value [32]
  output logic [127:0]                                  m_tdata
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  ephd_pkg::cmd_t push_cmd;
  ephd_pkg::cmd_t pop_cmd;

  ephd_front #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_push   (q_push),
    .q_cmd    (push_cmd),
    .q_full   (q_full)
  );

  ephd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  ephd_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== design/ephd_front.sv =====
// ----------------------------------------------------------------------------
// ephd_front
// Input stage: takes one word, decodes it into a command and reduces the
// window offset modulo the ring depth before queueing it.
// ----------------------------------------------------------------------------
module ephd_front #(
  parameter int RING_DEPTH  = 2048,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  input  logic [((SAMPLE_BITS+ephd_pkg::OFF_W+7)/8)*8-1:0] s_tdata,
  input  logic                                          s_tuser,
  output logic                                          q_push,
  output ephd_pkg::cmd_t                                q_cmd,
  input  logic                                          q_full
);

  localparam logic [ephd_pkg::CMD_OFF_W:0] DEPTH_C = (ephd_pkg::CMD_OFF_W+1)'(RING_DEPTH);

  logic                           busy;
  logic                           is_read;
  logic signed [31:0]             sample;
  logic [ephd_pkg::OFF_W-1:0]     offset;
  logic [ephd_pkg::CMD_OFF_W:0]   off_ext;
  logic                           off_big;
  logic signed [SAMPLE_BITS-1:0]  raw_s;

  assign raw_s   = s_tdata[SAMPLE_BITS-1:0];
  assign off_ext = (ephd_pkg::CMD_OFF_W+1)'(offset);
  assign off_big = is_read && (off_ext >= DEPTH_C);

  // Hand the held word on once its offset is in range
  assign q_push   = busy && !off_big && !q_full;
  assign s_tready = !busy || q_push;

  assign q_cmd.is_read = is_read;
  assign q_cmd.sample  = sample;
  assign q_cmd.offset  = ephd_pkg::CMD_OFF_W'(offset);

  // Hold the accepted word and step its offset down
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        busy    <= 1'b1;
        is_read <= (s_tuser == ephd_pkg::ACT_READ);
        sample  <= 32'(raw_s);
        offset  <= s_tdata[SAMPLE_BITS +: ephd_pkg::OFF_W];
      end else if (q_push) begin
        busy <= 1'b0;
      end else if (busy && off_big) begin
        offset <= ephd_pkg::OFF_W'(off_ext - DEPTH_C);
      end
    end
  end

endmodule

// ===== design/ephd_queue.sv =====
// ----------------------------------------------------------------------------
// ephd_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ephd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ephd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output ephd_pkg::cmd_t pop_cmd
);

  ephd_pkg::cmd_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_cmd = slots[rd_ptr];

  // Store and advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= push_cmd;
        wr_ptr        <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== design/ephd_back.sv =====
// ----------------------------------------------------------------------------
// ephd_back
// Execution sequencer: shared multiplier for scaling and mean update, peak
// hold and detection, ring memory with window readout, output register.
// ----------------------------------------------------------------------------
module ephd_back #(
  parameter int RING_DEPTH = 2048
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ephd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ephd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             q_valid,
  input  ephd_pkg::cmd_t                   q_cmd,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [127:0]                     m_tdata
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_C  = (PTR_W+1)'(RING_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_SAT1, ST_MUL2, ST_MEAN, ST_CENT, ST_UPDT,
    ST_RIDX, ST_RADR, ST_RDAT
  } state_t;

  state_t state;

  // Configuration
  logic [31:0]                   sample_scale;
  logic [15:0]                   mean_rate;
  logic [ephd_pkg::PEAK_W-1:0]   peak_threshold;
  logic [15:0]                   hold_count;

  // Detector state
  logic signed [31:0]            running_mean;
  logic [ephd_pkg::PEAK_W-1:0]   held_peak;
  logic [ephd_pkg::CNT_W-1:0]    since_peak_count;
  logic [PTR_W-1:0]              write_position;
  logic                          wrapped;
  logic [PTR_W-1:0]              capture_base;

  // Work registers
  ephd_pkg::cmd_t                cmd;
  logic signed [ephd_pkg::PROD_W-1:0] prod;
  logic signed [31:0]            scaled;
  logic signed [32:0]            diff;
  logic signed [31:0]            centered;
  logic [PTR_W-1:0]              rd_idx;
  logic                          entry_ok;

  // Ring memory
  logic signed [31:0]            ring [RING_DEPTH];
  logic signed [31:0]            rd_data;
  logic                          ring_we;
  logic                          ring_re;

  // Combinational helpers
  logic signed [32:0]            mul_a;
  logic signed [32:0]            mul_b;
  logic signed [32:0]            cent_wide;
  logic [ephd_pkg::PEAK_W-1:0]   mag;
  logic [ephd_pkg::CNT_W-1:0]    cnt_inc;
  logic                          new_peak;
  logic                          detect;
  logic [PTR_W-1:0]              wpos_next;
  logic [PTR_W:0]                idx_sum;
  logic                          out_free;
  logic                          out_load;

  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && ((state == ST_UPDT) || (state == ST_RDAT));
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign ring_we  = (state == ST_UPDT) && out_free;
  assign ring_re  = (state == ST_RADR);

  // Select operands of the shared multiplier
  always_comb begin
    if (state == ST_MUL2) begin
      mul_a = diff;
      mul_b = 33'(mean_rate);
    end else begin
      mul_a = 33'(cmd.sample);
      mul_b = 33'(sample_scale);
    end
  end

  // Peak hold and detection decision
  always_comb begin
    cent_wide = 33'(scaled) - 33'(running_mean);
    if (centered == 32'sh80000000) begin
      mag = ephd_pkg::PEAK_MAX;
    end else if (centered[31]) begin
      mag = ephd_pkg::PEAK_W'(-centered);
    end else begin
      mag = centered[ephd_pkg::PEAK_W-1:0];
    end
    new_peak = mag > held_peak;
    cnt_inc  = (since_peak_count < ephd_pkg::CNT_MAX) ? since_peak_count + 1'b1
                                                      : since_peak_count;
    detect   = !new_peak && (cnt_inc == ephd_pkg::CNT_W'(hold_count)) &&
               (held_peak > peak_threshold);
    wpos_next = (write_position == LAST_POS) ? '0 : write_position + 1'b1;
    idx_sum   = (PTR_W+1)'(capture_base) + (PTR_W+1)'(PTR_W'(cmd.offset));
  end

  // Ring write and registered read
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[write_position] <= centered;
    end
    if (ring_re) begin
      rd_data <= ring[rd_idx];
    end
  end

  // Sequencer, detector state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      m_tvalid         <= 1'b0;
      sample_scale     <= ephd_pkg::SCALE_RESET;
      mean_rate        <= ephd_pkg::RATE_RESET;
      peak_threshold   <= ephd_pkg::THRESHOLD_RESET;
      hold_count       <= ephd_pkg::HOLD_RESET;
      running_mean     <= '0;
      held_peak        <= '0;
      since_peak_count <= '0;
      write_position   <= '0;
      wrapped          <= 1'b0;
      capture_base     <= '0;
    end else begin
      // Take register writes
      if (cfg_we) begin
        unique case (cfg_index)
          ephd_pkg::REG_SAMPLE_SCALE:   sample_scale   <= cfg_data;
          ephd_pkg::REG_MEAN_RATE:      mean_rate      <= cfg_data[15:0];
          ephd_pkg::REG_PEAK_THRESHOLD: peak_threshold <= cfg_data[ephd_pkg::PEAK_W-1:0];
          ephd_pkg::REG_HOLD_COUNT:     hold_count     <= cfg_data[15:0];
        endcase
      end

      // Drop the output word once taken, unless a new one replaces it
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd   <= q_cmd;
            state <= q_cmd.is_read ? ST_RIDX : ST_MUL1;
          end
        end
        // Scale the raw sample
        ST_MUL1: begin
          prod  <= mul_a * mul_b;
          state <= ST_SAT1;
        end
        ST_SAT1: begin
          scaled <= ephd_pkg::sat32(prod >>> 8);
          diff   <= 33'(ephd_pkg::sat32(prod >>> 8)) - 33'(running_mean);
          state  <= ST_MUL2;
        end
        // Weight the mean step
        ST_MUL2: begin
          prod  <= mul_a * mul_b;
          state <= ST_MEAN;
        end
        ST_MEAN: begin
          running_mean <= ephd_pkg::sat32(ephd_pkg::PROD_W'(running_mean) + (prod >>> 16));
          state        <= ST_CENT;
        end
        ST_CENT: begin
          centered <= ephd_pkg::sat32(ephd_pkg::PROD_W'(cent_wide));
          state    <= ST_UPDT;
        end
        // Update peak hold, store the centered value and report the sample
        ST_UPDT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {32'd0, detect, (new_peak ? mag : held_peak),
                         running_mean, centered};
            write_position <= wpos_next;
            if (write_position == LAST_POS) begin
              wrapped <= 1'b1;
            end
            if (detect) begin
              held_peak        <= '0;
              since_peak_count <= '0;
              capture_base     <= wpos_next;
            end else if (new_peak) begin
              held_peak        <= mag;
              since_peak_count <= '0;
            end else begin
              since_peak_count <= cnt_inc;
            end
            state <= ST_IDLE;
          end
        end
        // Locate the window entry
        ST_RIDX: begin
          rd_idx <= (idx_sum >= DEPTH_C) ? PTR_W'(idx_sum - DEPTH_C) : PTR_W'(idx_sum);
          state  <= ST_RADR;
        end
        ST_RADR: begin
          entry_ok <= wrapped || (rd_idx < write_position);
          state    <= ST_RDAT;
        end
        ST_RDAT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {(entry_ok ? rd_data : 32'sd0), 1'b0, held_peak,
                         running_mean, 32'd0};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
